// ===== rtl/assert_macros.svh =====
// assertion macros shared by the classifier rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SPC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, checked outside reset
`define SPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/spc_pkg.sv =====
// shared types and constants of the ssh payload classifier
// no dependencies; used by spc_result_if and all rtl modules
package spc_pkg;

    localparam int KIND_W  = 3;
    localparam int IDX_W   = 4;
    localparam int FIELD_W = 16;
    localparam int HDR_LEN = 6;
    // wide enough for a walk position plus a 32-bit list length plus 4
    localparam int WIDE_W  = 34;

    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_H    = 8'h48;
    localparam logic [7:0] CHAR_DASH = 8'h2d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] CHAR_CR   = 8'h0d;

    localparam logic [7:0] CODE_KEXINIT    = 8'd20;
    localparam logic [7:0] CODE_NEWKEYS    = 8'd21;
    localparam logic [7:0] CODE_RANGE_LO   = 8'd30;
    localparam logic [7:0] CODE_KNOWN_HI   = 8'd34;
    localparam logic [7:0] CODE_RANGE_HI   = 8'd49;

    typedef enum logic [KIND_W-1:0] {
        KIND_IDENT     = 3'd0,
        KIND_HANDSHAKE = 3'd1,
        KIND_KEXINIT   = 3'd2,
        KIND_ENCRYPTED = 3'd3,
        KIND_LIST      = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                result_kind;
        logic [7:0]           message_code;
        logic                 code_known;
        logic [31:0]          packet_length;
        logic [7:0]           padding_length;
        logic [31:0]          body_length;
        logic [IDX_W-1:0]     field_index;
        logic [FIELD_W-1:0]   field_offset;
        logic [FIELD_W-1:0]   field_length;
        logic                 first_kex_follows;
        logic                 last_result;
    } result_t;

    // classification of a finished payload plus the number of name lists to report
    typedef struct packed {
        result_t              res;
        logic [IDX_W-1:0]     entries;
    } verdict_t;

endpackage

// ===== rtl/spc_byte_if.sv =====
// payload byte channel: valid/ready handshake with one byte and an end marker
// depends on nothing
interface spc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, payload_byte, last_byte, input ready);
    modport sink   (input valid, payload_byte, last_byte, output ready);
endinterface

// ===== rtl/spc_result_if.sv =====
// result channel: valid/ready handshake carrying one classification record
// depends on spc_pkg for field widths
interface spc_result_if;
    logic                          valid;
    logic                          ready;
    logic [spc_pkg::KIND_W-1:0]    result_kind;
    logic [7:0]                    message_code;
    logic                          code_known;
    logic [31:0]                   packet_length;
    logic [7:0]                    padding_length;
    logic [31:0]                   body_length;
    logic [spc_pkg::IDX_W-1:0]     field_index;
    logic [spc_pkg::FIELD_W-1:0]   field_offset;
    logic [spc_pkg::FIELD_W-1:0]   field_length;
    logic                          first_kex_follows;
    logic                          last_result;

    modport source (output valid, result_kind, message_code, code_known, packet_length,
                    padding_length, body_length, field_index, field_offset, field_length,
                    first_kex_follows, last_result, input ready);
    modport sink   (input valid, result_kind, message_code, code_known, packet_length,
                    padding_length, body_length, field_index, field_offset, field_length,
                    first_kex_follows, last_result, output ready);
endinterface

// ===== rtl/ssh_payload_classifier_unit.sv =====
// top level of the ssh payload classifier: input register, scanner, result register
// depends on spc_pkg, spc_byte_if, spc_result_if, spc_scan and assert_macros.svh
//
// channel   dir   carries
// -------   ---   ----------------------------------------------------------
// stream    in    one payload byte per transaction, last_byte ends the payload
// report    out   one classification record per transaction, last_result ends it
//
// throughput: one byte per cycle while no name list entries are pending; the final byte is
//   scanned from the input register and its result is written to the result register
// a key exchange init stalls the scan while its reported name list entries are sent one
//   by one from the result register
// reset: rst_n clears all control and scan state at once; the name list store
//   is not cleared, it is only read at entries written during the same payload
// stalls: a full result register blocks only a final byte; ordinary bytes flow except while list entries are emitted
`include "assert_macros.svh"

module ssh_payload_classifier_unit #(
    parameter int PAYLOAD_LEN_BITS = 16,
    parameter int NAME_LIST_COUNT  = 10,
    parameter int COOKIE_BYTES     = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    spc_byte_if.sink      stream,
    spc_result_if.source  report
);

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic        in_last_reg, in_last_next;

    // result register and list entry sequencer
    logic                       out_valid_reg, out_valid_next;
    spc_pkg::result_t           out_data_reg, out_data_next;
    logic [spc_pkg::IDX_W-1:0]  emit_left_reg, emit_left_next;
    logic [spc_pkg::IDX_W-1:0]  emit_idx_reg, emit_idx_next;

    spc_pkg::verdict_t            verdict;
    logic [spc_pkg::FIELD_W-1:0]  rd_offset;
    logic [spc_pkg::FIELD_W-1:0]  rd_length;

    logic out_free;
    logic emitting;
    logic advance;
    logic in_take;

    assign out_free = !out_valid_reg || report.ready;
    assign emitting = (emit_left_reg != '0);
    // a final byte needs room in the result register, other bytes do not
    assign advance  = in_valid_reg && !emitting && (!in_last_reg || out_free);
    assign stream.ready = !in_valid_reg || advance;
    assign in_take  = stream.valid && stream.ready;

    // the store read is registered, so it is addressed with the next entry index
    spc_scan #(
        .CNT_W      (PAYLOAD_LEN_BITS),
        .LIST_COUNT (NAME_LIST_COUNT),
        .COOKIE     (COOKIE_BYTES)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .payload_byte (in_byte_reg),
        .last_byte    (in_last_reg),
        .rd_index     (emit_idx_next),
        .verdict      (verdict),
        .rd_offset    (rd_offset),
        .rd_length    (rd_length)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = stream.payload_byte;
            in_last_next  = stream.last_byte;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        emit_left_next = emit_left_reg;
        emit_idx_next  = emit_idx_reg;
        if (advance && in_last_reg)
        begin
            // payload finished: headline record, then any name list entries
            out_valid_next = 1'b1;
            out_data_next  = verdict.res;
            emit_left_next = verdict.entries;
            emit_idx_next  = '0;
        end
        else if (emitting && out_free)
        begin
            out_valid_next             = 1'b1;
            out_data_next              = '0;
            out_data_next.result_kind  = spc_pkg::KIND_LIST;
            out_data_next.field_index  = emit_idx_reg;
            out_data_next.field_offset = rd_offset;
            out_data_next.field_length = rd_length;
            out_data_next.last_result  = (emit_left_reg == spc_pkg::IDX_W'(1));
            emit_left_next             = emit_left_reg - spc_pkg::IDX_W'(1);
            emit_idx_next              = emit_idx_reg + spc_pkg::IDX_W'(1);
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            emit_left_reg <= '0;
            emit_idx_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            emit_left_reg <= emit_left_next;
            emit_idx_reg  <= emit_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        in_last_reg  <= in_last_next;
        out_data_reg <= out_data_next;
    end

    assign report.valid             = out_valid_reg;
    assign report.result_kind       = out_data_reg.result_kind;
    assign report.message_code      = out_data_reg.message_code;
    assign report.code_known        = out_data_reg.code_known;
    assign report.packet_length     = out_data_reg.packet_length;
    assign report.padding_length    = out_data_reg.padding_length;
    assign report.body_length       = out_data_reg.body_length;
    assign report.field_index       = out_data_reg.field_index;
    assign report.field_offset      = out_data_reg.field_offset;
    assign report.field_length      = out_data_reg.field_length;
    assign report.first_kex_follows = out_data_reg.first_kex_follows;
    assign report.last_result       = out_data_reg.last_result;

    // pending list entries always sit behind a visible record
    `SPC_ASSERT_IMPLY(a_entries_behind_record, clk, rst_n, emitting, out_valid_reg)
    // the closing record of a payload leaves nothing queued
    `SPC_ASSERT_IMPLY(a_closing_record_drains, clk, rst_n,
        out_valid_reg && out_data_reg.last_result, emit_left_reg == '0)
    // an entry taken before the end is followed at once by the next entry
    `SPC_ASSERT_NEXT(a_entries_contiguous, clk, rst_n,
        out_valid_reg && report.ready && !out_data_reg.last_result
            && out_data_reg.result_kind == spc_pkg::KIND_LIST,
        out_valid_reg && out_data_reg.result_kind == spc_pkg::KIND_LIST)

endmodule

// ===== rtl/spc_scan.sv =====
// per-byte payload scanner: header capture, name list walk and final verdict
// depends on spc_pkg and assert_macros.svh
`include "assert_macros.svh"

module spc_scan #(
    parameter int CNT_W      = 16,
    parameter int LIST_COUNT = 10,
    parameter int COOKIE     = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [7:0]                   payload_byte,
    input  logic                         last_byte,
    input  logic [spc_pkg::IDX_W-1:0]    rd_index,
    output spc_pkg::verdict_t            verdict,
    output logic [spc_pkg::FIELD_W-1:0]  rd_offset,
    output logic [spc_pkg::FIELD_W-1:0]  rd_length
);

    localparam int WALK_W = CNT_W + 1;
    localparam int SEL_W  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam logic [CNT_W-1:0]  MAX_COUNT  = {CNT_W{1'b1}};
    localparam logic [WALK_W-1:0] WALK_CAP   = {1'b1, {CNT_W{1'b0}}};
    localparam logic [WALK_W-1:0] WALK_START = WALK_W'(spc_pkg::HDR_LEN + COOKIE);
    localparam logic [spc_pkg::IDX_W-1:0] LIST_MAX = spc_pkg::IDX_W'(LIST_COUNT);
    localparam int W = spc_pkg::WIDE_W;

    logic [CNT_W-1:0]           count_reg, count_next;
    logic [7:0]                 hdr_reg [spc_pkg::HDR_LEN];
    logic [7:0]                 hdr_next [spc_pkg::HDR_LEN];
    logic [7:0]                 prev_reg;
    logic [WALK_W-1:0]          walk_reg, walk_next;
    logic [31:0]                acc_reg, acc_next;
    logic [spc_pkg::IDX_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]           last_off_reg, last_off_next;
    logic [7:0]                 flag_reg, flag_next;

    logic [spc_pkg::FIELD_W-1:0] off_mem [LIST_COUNT];
    logic [spc_pkg::FIELD_W-1:0] len_mem [LIST_COUNT];
    logic [spc_pkg::FIELD_W-1:0] rd_offset_reg;
    logic [spc_pkg::FIELD_W-1:0] rd_length_reg;

    logic                positioned;
    logic                walking;
    logic                in_win;
    logic                record;
    logic                flag_hit;
    logic [WALK_W-1:0]   pos_w;
    logic [WALK_W-1:0]   rel;
    logic [31:0]         acc_shift;
    logic [W-1:0]        nxt_wide;
    logic [WALK_W-1:0]   walk_capped;

    // per-byte state update
    always_comb
    begin
        positioned = (count_reg != MAX_COUNT);
        count_next = positioned ? count_reg + CNT_W'(1) : count_reg;
        for (int i = 0; i < spc_pkg::HDR_LEN; i++)
        begin
            hdr_next[i] = (positioned && count_reg == CNT_W'(i)) ? payload_byte : hdr_reg[i];
        end
        pos_w       = {1'b0, count_reg};
        walking     = (found_reg < LIST_MAX);
        rel         = pos_w - walk_reg;
        in_win      = walking && positioned && (pos_w >= walk_reg) && (rel < WALK_W'(4));
        record      = in_win && (rel == WALK_W'(3));
        acc_shift   = {acc_reg[23:0], payload_byte};
        nxt_wide    = W'(walk_reg) + W'(4) + W'(acc_shift);
        walk_capped = (nxt_wide > W'(WALK_CAP)) ? WALK_CAP : nxt_wide[WALK_W-1:0];
        flag_hit    = !walking && positioned && (pos_w == walk_reg);

        acc_next      = record ? 32'd0 : (in_win ? acc_shift : acc_reg);
        walk_next     = record ? walk_capped : walk_reg;
        found_next    = record ? found_reg + spc_pkg::IDX_W'(1) : found_reg;
        last_off_next = record ? walk_reg[CNT_W-1:0] : last_off_reg;
        flag_next     = flag_hit ? payload_byte : flag_reg;
    end

    // classification of the payload as it stands after this byte
    logic [W-1:0]               len_w;
    logic [31:0]                plen;
    logic [7:0]                 pad;
    logic [7:0]                 code;
    logic                       is_ident;
    logic                       code_ok;
    logic                       known;
    logic                       is_hs;
    logic                       is_kex;
    logic                       last_ok;
    logic [spc_pkg::IDX_W-1:0]  entries;
    logic                       fkf;
    logic [31:0]                text_len;
    logic [31:0]                body;

    always_comb
    begin
        len_w = W'(count_next);
        plen  = {hdr_next[0], hdr_next[1], hdr_next[2], hdr_next[3]};
        pad   = hdr_next[4];
        code  = hdr_next[5];

        is_ident = (count_next >= CNT_W'(5)) && (hdr_next[0] == spc_pkg::CHAR_S)
                   && (hdr_next[1] == spc_pkg::CHAR_S) && (hdr_next[2] == spc_pkg::CHAR_H)
                   && (hdr_next[3] == spc_pkg::CHAR_DASH) && (payload_byte == spc_pkg::CHAR_LF);
        text_len = 32'(count_next) - ((prev_reg == spc_pkg::CHAR_CR) ? 32'd2 : 32'd1);

        code_ok = code inside {spc_pkg::CODE_KEXINIT, spc_pkg::CODE_NEWKEYS,
                               [spc_pkg::CODE_RANGE_LO:spc_pkg::CODE_RANGE_HI]};
        known   = code inside {spc_pkg::CODE_KEXINIT, spc_pkg::CODE_NEWKEYS,
                               [spc_pkg::CODE_RANGE_LO:spc_pkg::CODE_KNOWN_HI]};
        is_hs   = (count_next >= CNT_W'(spc_pkg::HDR_LEN)) && (W'(plen) + W'(4) <= len_w)
                  && (32'(pad) <= plen) && code_ok;
        is_kex  = is_hs && (code == spc_pkg::CODE_KEXINIT);
        body    = (plen >= 32'(pad) + 32'd2) ? plen - 32'(pad) - 32'd2 : 32'd0;

        // lists run back to back, so only the most recent one can overrun the end
        last_ok = !record && (W'(last_off_reg) + W'(4) < len_w) && (W'(walk_reg) <= len_w);
        if (found_next == '0)
        begin
            entries = '0;
        end
        else if (last_ok)
        begin
            entries = found_next;
        end
        else
        begin
            entries = found_next - spc_pkg::IDX_W'(1);
        end
        fkf = (entries == LIST_MAX) && (W'(walk_reg) < len_w) && (flag_next != 8'd0);

        verdict = '0;
        if (is_ident)
        begin
            verdict.res.result_kind = spc_pkg::KIND_IDENT;
            verdict.res.body_length = text_len;
            verdict.res.last_result = 1'b1;
        end
        else if (is_hs)
        begin
            verdict.res.result_kind    = is_kex ? spc_pkg::KIND_KEXINIT : spc_pkg::KIND_HANDSHAKE;
            verdict.res.message_code   = code;
            verdict.res.code_known     = known;
            verdict.res.packet_length  = plen;
            verdict.res.padding_length = pad;
            verdict.res.body_length    = body;
            verdict.res.first_kex_follows = is_kex && fkf;
            verdict.res.last_result    = !(is_kex && entries != '0);
            verdict.entries            = is_kex ? entries : '0;
        end
        else
        begin
            verdict.res.result_kind = spc_pkg::KIND_ENCRYPTED;
            verdict.res.last_result = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            prev_reg     <= '0;
            walk_reg     <= WALK_START;
            acc_reg      <= '0;
            found_reg    <= '0;
            last_off_reg <= '0;
            flag_reg     <= '0;
            for (int i = 0; i < spc_pkg::HDR_LEN; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            if (last_byte)
            begin
                count_reg    <= '0;
                prev_reg     <= '0;
                walk_reg     <= WALK_START;
                acc_reg      <= '0;
                found_reg    <= '0;
                last_off_reg <= '0;
                flag_reg     <= '0;
                for (int i = 0; i < spc_pkg::HDR_LEN; i++)
                begin
                    hdr_reg[i] <= '0;
                end
            end
            else
            begin
                count_reg    <= count_next;
                prev_reg     <= payload_byte;
                walk_reg     <= walk_next;
                acc_reg      <= acc_next;
                found_reg    <= found_next;
                last_off_reg <= last_off_next;
                flag_reg     <= flag_next;
                for (int i = 0; i < spc_pkg::HDR_LEN; i++)
                begin
                    hdr_reg[i] <= hdr_next[i];
                end
            end
        end
    end

    // name list store, only read below the reported entry count
    // read data is registered: rd_index names the entry wanted in the next cycle
    always_ff @(posedge clk)
    begin
        if (step && record)
        begin
            off_mem[found_reg[SEL_W-1:0]] <= spc_pkg::FIELD_W'(walk_reg);
            len_mem[found_reg[SEL_W-1:0]] <= acc_shift[spc_pkg::FIELD_W-1:0];
        end
        rd_offset_reg <= off_mem[rd_index[SEL_W-1:0]];
        rd_length_reg <= len_mem[rd_index[SEL_W-1:0]];
    end

    assign rd_offset = rd_offset_reg;
    assign rd_length = rd_length_reg;

    `SPC_ASSERT_NEXT(a_state_clears_after_payload, clk, rst_n, step && last_byte,
        count_reg == '0 && found_reg == '0 && walk_reg == WALK_START)

endmodule

// ===== tb/ssh_payload_classifier_unit_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of ssh_payload_classifier_unit: directed and random payloads
// depends on spc_pkg, spc_byte_if, spc_result_if and the classifier rtl
module ssh_payload_classifier_unit_test;
    import spc_pkg::*;

    localparam int LEN_BITS     = 16;
    localparam int LISTS        = 10;
    localparam int COOKIE_BYTES = 16;
    localparam longint unsigned COUNT_MAX  = (64'd1 << LEN_BITS) - 1;
    localparam longint unsigned WALK_CAP   = COUNT_MAX + 1;
    localparam longint unsigned WALK_START = HDR_LEN + COOKIE_BYTES;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int TAIL_CYCLES    = 20;
    localparam int QUIET_LIMIT    = 2000;
    localparam int STALL_HOLD     = 150;
    localparam int RANDOM_BYTES   = 190;
    localparam int RANDOM_REPORTS = 24;
    localparam int QUIET_TAIL     = 60;

    typedef logic [7:0] byte_q_t [$];

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    spc_byte_if   stream ();
    spc_result_if report ();

    ssh_payload_classifier_unit #(
        .PAYLOAD_LEN_BITS (LEN_BITS),
        .NAME_LIST_COUNT  (LISTS),
        .COOKIE_BYTES     (COOKIE_BYTES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .report (report)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // reports the predictor expects, oldest first
    result_t pending_reports [$];

    int          errors         = 0;
    int unsigned reports_seen   = 0;
    int unsigned accepted_bytes = 0;
    int          quiet_cycles   = 0;
    bit          idle_on        = 1'b1;
    int          stall_left     = 0;
    int          burst_left     = 0;

    // predictor copy of the scan state
    int unsigned     byte_pos;
    logic [7:0]      hdr_bytes [HDR_LEN];
    logic [7:0]      tail_bytes [2];
    longint unsigned list_pos;
    logic [31:0]     len_word;
    int unsigned     lists_seen;
    longint unsigned list_off [LISTS];
    logic [31:0]     list_len [LISTS];
    logic [7:0]      kex_flag;

    function automatic void clear_scan();
        byte_pos   = 0;
        hdr_bytes  = '{default: 8'h00};
        tail_bytes = '{default: 8'h00};
        list_pos   = WALK_START;
        len_word   = '0;
        lists_seen = 0;
        kex_flag   = 8'h00;
    endfunction

    // advance the predicted scan by one byte; on the final byte classify the payload
    function automatic void classify_byte(input logic [7:0] b, input logic fin);
        longint unsigned pos, nxt, len, plen, pad, body;
        logic [7:0]      code;
        bit              code_ok, known, fkf;
        int unsigned     good;
        result_t         recs [$];
        result_t         r, ent;
        tail_bytes[1] = tail_bytes[0];
        tail_bytes[0] = b;
        // past saturation a byte is no longer positioned
        if (byte_pos < COUNT_MAX) begin
            pos = byte_pos;
            byte_pos++;
            if (pos < HDR_LEN)
                hdr_bytes[pos] = b;
            if (lists_seen < LISTS) begin
                if (pos >= list_pos && pos < list_pos + 4) begin
                    len_word = {len_word[23:0], b};
                    if (pos == list_pos + 3) begin
                        nxt = list_pos + 4 + len_word;
                        list_off[lists_seen] = list_pos;
                        list_len[lists_seen] = len_word;
                        // a huge list length parks the walk past any payload
                        list_pos = (nxt > WALK_CAP) ? WALK_CAP : nxt;
                        lists_seen++;
                        len_word = '0;
                    end
                end
            end else if (pos == list_pos) begin
                kex_flag = b;
            end
        end
        if (!fin)
            return;

        len = byte_pos;
        r = '0;
        if (len >= 5 && hdr_bytes[0] == CHAR_S && hdr_bytes[1] == CHAR_S &&
            hdr_bytes[2] == CHAR_H && hdr_bytes[3] == CHAR_DASH && tail_bytes[0] == CHAR_LF)
        begin
            r.result_kind = KIND_IDENT;
            r.body_length = 32'(len - ((tail_bytes[1] == CHAR_CR) ? 2 : 1));
            recs.push_back(r);
        end else begin
            plen = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
            pad  = hdr_bytes[4];
            code = hdr_bytes[5];
            code_ok = code == CODE_KEXINIT || code == CODE_NEWKEYS ||
                      (code >= CODE_RANGE_LO && code <= CODE_RANGE_HI);
            if (len >= HDR_LEN && plen + 4 <= len && pad <= plen && code_ok) begin
                known = code == CODE_KEXINIT || code == CODE_NEWKEYS ||
                        (code >= CODE_RANGE_LO && code <= CODE_KNOWN_HI);
                body = (plen >= pad + 2) ? plen - pad - 2 : 0;
                r.message_code   = code;
                r.code_known     = known;
                r.packet_length  = plen[31:0];
                r.padding_length = pad[7:0];
                r.body_length    = body[31:0];
                if (code == CODE_KEXINIT) begin
                    good = 0;
                    fkf  = 1'b0;
                    if (len > WALK_START) begin
                        // lists count in order up to the first that does not fit
                        for (int i = 0; i < lists_seen; i++) begin
                            if (list_off[i] + 4 >= len)
                                break;
                            if (list_off[i] + 4 + list_len[i] > len)
                                break;
                            good++;
                        end
                        if (good == LISTS && list_pos < len && kex_flag != 8'h00)
                            fkf = 1'b1;
                    end
                    r.result_kind       = KIND_KEXINIT;
                    r.first_kex_follows = fkf;
                    recs.push_back(r);
                    for (int i = 0; i < good; i++) begin
                        ent = '0;
                        ent.result_kind  = KIND_LIST;
                        ent.field_index  = IDX_W'(i);
                        ent.field_offset = list_off[i][FIELD_W-1:0];
                        ent.field_length = list_len[i][FIELD_W-1:0];
                        recs.push_back(ent);
                    end
                end else begin
                    r.result_kind = KIND_HANDSHAKE;
                    recs.push_back(r);
                end
            end else begin
                r.result_kind = KIND_ENCRYPTED;
                recs.push_back(r);
            end
        end
        foreach (recs[i]) begin
            r = recs[i];
            r.last_result = (i == recs.size() - 1);
            pending_reports.push_back(r);
        end
        clear_scan();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic check_report();
        result_t got, want;
        got.result_kind       = kind_t'(report.result_kind);
        got.message_code      = report.message_code;
        got.code_known        = report.code_known;
        got.packet_length     = report.packet_length;
        got.padding_length    = report.padding_length;
        got.body_length       = report.body_length;
        got.field_index       = report.field_index;
        got.field_offset      = report.field_offset;
        got.field_length      = report.field_length;
        got.first_kex_follows = report.first_kex_follows;
        got.last_result       = report.last_result;
        reports_seen++;
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none actual kind %0d",
                     $time, got.result_kind);
            errors++;
        end else begin
            want = pending_reports.pop_front();
            check_field("result_kind", want.result_kind, got.result_kind);
            check_field("message_code", want.message_code, got.message_code);
            check_field("code_known", want.code_known, got.code_known);
            check_field("packet_length", want.packet_length, got.packet_length);
            check_field("padding_length", want.padding_length, got.padding_length);
            check_field("body_length", want.body_length, got.body_length);
            check_field("field_index", want.field_index, got.field_index);
            check_field("field_offset", want.field_offset, got.field_offset);
            check_field("field_length", want.field_length, got.field_length);
            check_field("first_kex_follows", want.first_kex_follows, got.first_kex_follows);
            check_field("last_result", want.last_result, got.last_result);
        end
    endtask

    // byte transactions feed the predictor as the dut takes them
    always @(posedge clk) begin
        if (rst_n && stream.valid && stream.ready) begin
            classify_byte(stream.payload_byte, stream.last_byte);
            accepted_bytes++;
        end
    end

    // every report transaction is checked against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && report.valid && report.ready)
            check_report();
    end

    // watchdog: too long without any transaction means the dut is stuck
    always @(posedge clk) begin
        if ((stream.valid && stream.ready) || (report.valid && report.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // report receiver: a requested long hold first, then random stall bursts
    initial begin
        report.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                report.ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                report.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(0, 5);
                report.ready <= 1'b0;
            end else begin
                report.ready <= 1'b1;
            end
        end
    end

    // after an optional random idle gap, offer one byte transaction at the falling edge and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        repeat (gap) begin
            @(negedge clk);
            stream.valid <= 1'b0;
        end
        @(negedge clk);
        stream.valid        <= 1'b1;
        stream.payload_byte <= b;
        stream.last_byte    <= fin;
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
    endtask

    task automatic send_payload(input byte_q_t pl);
        foreach (pl[i])
            send_byte(pl[i], i == pl.size() - 1);
    endtask

    // stop offering and wait until every expected report is back
    task automatic drain();
        @(negedge clk);
        stream.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    function automatic void push_u32(ref byte_q_t q, input logic [31:0] v);
        q.push_back(v[31:24]);
        q.push_back(v[23:16]);
        q.push_back(v[15:8]);
        q.push_back(v[7:0]);
    endfunction

    // "SSH-" plus random text up to text_len, then an optional CR and the LF
    function automatic byte_q_t make_ident(input int unsigned text_len, input bit with_cr);
        byte_q_t q;
        q = {CHAR_S, CHAR_S, CHAR_H, CHAR_DASH};
        while (q.size() < text_len)
            q.push_back(8'($urandom));
        if (with_cr)
            q.push_back(CHAR_CR);
        q.push_back(CHAR_LF);
        return q;
    endfunction

    function automatic byte_q_t make_handshake(input logic [31:0] plen, input logic [7:0] pad,
                                               input logic [7:0] code, input int unsigned total);
        byte_q_t q;
        push_u32(q, plen);
        q.push_back(pad);
        q.push_back(code);
        while (q.size() < total)
            q.push_back(8'($urandom));
        return q;
    endfunction

    // key exchange init: header, cookie, name lists, optional flag; cut != 0 truncates
    function automatic byte_q_t make_kexinit(input logic [31:0] lens [LISTS], input bit with_flag,
                                             input logic [7:0] flag, input int unsigned cut);
        byte_q_t     q;
        int          plen;
        logic [7:0]  pad;
        logic [7:0]  hdr [HDR_LEN];
        int unsigned n;
        repeat (HDR_LEN + COOKIE_BYTES)
            q.push_back(8'($urandom));
        for (int i = 0; i < LISTS; i++) begin
            push_u32(q, lens[i]);
            // long lists only get a few content bytes, they never fit anyway
            n = (lens[i] > 6) ? $urandom_range(0, 6) : lens[i];
            repeat (n)
                q.push_back(8'($urandom));
        end
        if (with_flag)
            q.push_back(flag);
        if (cut != 0)
            while (q.size() > cut)
                void'(q.pop_back());
        plen = (q.size() >= HDR_LEN) ? q.size() - 4 - $urandom_range(0, 2) : 2;
        pad  = 8'($urandom_range(0, (plen < 8) ? plen : 8));
        hdr  = '{plen[31:24], plen[23:16], plen[15:8], plen[7:0], pad, CODE_KEXINIT};
        for (int i = 0; i < HDR_LEN && i < q.size(); i++)
            q[i] = hdr[i];
        return q;
    endfunction

    // shortest identification lines, with LF and with CR LF
    task automatic test_identification();
        send_payload(make_ident(4, 1'b0));
        send_payload(make_ident(4, 1'b1));
        drain();
    endtask

    // minimal handshake, and a last-range code whose body length clamps at zero
    task automatic test_handshake();
        send_payload(make_handshake(32'd2, 8'd0, CODE_NEWKEYS, 6));
        send_payload(make_handshake(32'd3, 8'd3, CODE_RANGE_HI, 7));
        drain();
    endtask

    // single-byte payloads at both byte extremes
    task automatic test_encrypted();
        byte_q_t pl;
        pl = {8'hFF};
        send_payload(pl);
        pl = {8'h00};
        send_payload(pl);
        drain();
    endtask

    // full key exchange init with empty lists and a set flag, then one too short to walk
    task automatic test_kexinit();
        logic [31:0] lens [LISTS];
        lens = '{default: 32'h0};
        send_payload(make_kexinit(lens, 1'b1, 8'h01, 0));
        send_payload(make_handshake(32'd2, 8'd0, CODE_KEXINIT, 6));
        drain();
    endtask

    // receiver holds off long enough for finished payloads to back up into the input
    task automatic test_backpressure();
        byte_q_t pl;
        stall_left = STALL_HOLD;
        repeat (16) begin
            pl = {8'($urandom)};
            send_payload(pl);
        end
        send_payload(make_handshake(32'd4, 8'd1, CODE_KNOWN_HI, 9));
        drain();
    endtask

    task automatic test_random();
        byte_q_t     pl;
        logic [31:0] lens [LISTS];
        int unsigned start_bytes, start_reports, pick, total, plen, pad, k, r;
        logic [7:0]  code;
        start_bytes   = accepted_bytes;
        start_reports = reports_seen;
        while (accepted_bytes - start_bytes < RANDOM_BYTES ||
               reports_seen - start_reports < RANDOM_REPORTS) begin
            // the tail of the run goes without idling on either side
            if (accepted_bytes - start_bytes >= RANDOM_BYTES - QUIET_TAIL)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                pl = make_ident($urandom_range(4, 14), $urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0) begin
                    // broken line: no LF at the end or a damaged prefix
                    if ($urandom_range(0, 1))
                        void'(pl.pop_back());
                    else
                        pl[$urandom_range(0, 3)] = 8'($urandom);
                end
            end else if (pick < 55) begin
                total = $urandom_range(6, 24);
                plen  = $urandom_range(0, total - 4);
                pad   = $urandom_range(0, plen);
                k     = $urandom_range(0, 20);
                code  = (k == 0) ? CODE_NEWKEYS : CODE_RANGE_LO + 8'(k - 1);
                if (pick >= 40) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            r = $urandom_range(0, 2);
                            if (r == 0)
                                code = 8'($urandom_range(0, CODE_KEXINIT - 1));
                            else if (r == 1)
                                code = 8'($urandom_range(CODE_NEWKEYS + 1, CODE_RANGE_LO - 1));
                            else
                                code = 8'($urandom_range(CODE_RANGE_HI + 1, 8'hFF));
                        end
                        1: plen = $urandom_range(0, 1) ? 32'hFFFF_FFFF : total - 3;
                        default: pad = plen + $urandom_range(1, 8);
                    endcase
                end
                pl = make_handshake(plen, pad[7:0], code, total);
            end else if (pick < 85) begin
                foreach (lens[i]) begin
                    r = $urandom_range(0, 99);
                    if (r < 75)
                        lens[i] = $urandom_range(0, 3);
                    else if (r < 97)
                        lens[i] = $urandom_range(4, 12);
                    else if (r < 98)
                        lens[i] = $urandom;
                    else
                        lens[i] = 32'hFFFF_FFFF;
                end
                pl = make_kexinit(lens, $urandom_range(0, 3) != 0,
                                  $urandom_range(0, 1) ? 8'h00 : 8'($urandom),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : 0);
            end else begin
                pl = {};
                repeat ($urandom_range(1, 12))
                    pl.push_back(8'($urandom));
            end
            send_payload(pl);
        end
        drain();
    endtask

    initial begin
        stream.valid        = 1'b0;
        stream.payload_byte = 8'h00;
        stream.last_byte    = 1'b0;
        clear_scan();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_identification();
        test_handshake();
        test_encrypted();
        test_kexinit();
        test_backpressure();
        test_random();

        // let any stray report show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
